>>> rtl/core/fdct_pkg.sv
// Package: types, constants and rounding helper for the 8x8 forward DCT.
package fdct_pkg;

	localparam int SAMPLE_BITS = 9;
	localparam int COEF_BITS   = 15;
	localparam int WORK_BITS   = 32;
	localparam int PROD_BITS   = 50;

	localparam logic [16:0] C1 = 17'd64277;
	localparam logic [16:0] C2 = 17'd60547;
	localparam logic [16:0] C3 = 17'd54491;
	localparam logic [16:0] C4 = 17'd46341;
	localparam logic [16:0] C5 = 17'd36410;
	localparam logic [16:0] C6 = 17'd25080;
	localparam logic [16:0] C7 = 17'd12785;
	localparam logic [PROD_BITS-1:0] HALF = PROD_BITS'(32768);

	typedef enum logic [2:0] {
		ST_LOAD,
		ST_READ,
		ST_CALC,
		ST_WRITE,
		ST_EMIT
	} state_t;

	typedef enum logic [4:0] {
		OP_A,
		OP_M5,
		OP_M7,
		OP_E,
		OP_Y0,
		OP_Y1A,
		OP_Y1B,
		OP_Y2A,
		OP_Y2B,
		OP_Y3A,
		OP_Y3B,
		OP_Y4,
		OP_Y5A,
		OP_Y5B,
		OP_Y6A,
		OP_Y6B,
		OP_Y7A,
		OP_Y7B,
		OP_DONE
	} op_t;

	function automatic logic signed [WORK_BITS-1:0] round16(input logic signed [PROD_BITS-1:0] v);
		logic signed [PROD_BITS-1:0] t;
		begin
			t = v + $signed(HALF);
			round16 = WORK_BITS'(t >>> 16);
		end
	endfunction

endpackage

>>> rtl/core/fdct_line.sv
// One 8-point DCT line engine: one shared multiplier under a step sequencer.
module fdct_line
	import fdct_pkg::*;
(
	input  logic                               clk,
	input  logic                               arst_n,
	input  logic                               start,
	input  logic signed [7:0][WORK_BITS-1:0]   x,
	output logic signed [7:0][WORK_BITS-1:0]   y,
	output logic                               done
);

	op_t op_q;
	logic signed [WORK_BITS-1:0] a_q [8];
	logic signed [WORK_BITS-1:0] e_q [8];
	logic signed [WORK_BITS-1:0] m5_q, m7_q;
	logic signed [PROD_BITS-1:0] acc_q;
	logic signed [WORK_BITS-1:0] mul_a;
	logic        [16:0]          mul_c;
	logic signed [PROD_BITS-1:0] prod;
	logic                        rnd;
	logic [2:0]                  yidx;

	always_comb begin
		mul_a = '0;
		mul_c = C4;
		rnd   = 1'b0;
		yidx  = 3'd0;
		unique case (op_q)
			OP_M5:  begin mul_a = a_q[6] - a_q[5]; mul_c = C4; end
			OP_M7:  begin mul_a = a_q[5] + a_q[6]; mul_c = C4; end
			OP_Y0:  begin mul_a = e_q[0] + e_q[1]; mul_c = C4; rnd = 1'b1; yidx = 3'd0; end
			OP_Y1A: begin mul_a = e_q[4]; mul_c = C7; end
			OP_Y1B: begin mul_a = e_q[7]; mul_c = C1; rnd = 1'b1; yidx = 3'd1; end
			OP_Y2A: begin mul_a = e_q[2]; mul_c = C6; end
			OP_Y2B: begin mul_a = e_q[3]; mul_c = C2; rnd = 1'b1; yidx = 3'd2; end
			OP_Y3A: begin mul_a = e_q[6]; mul_c = C3; end
			OP_Y3B: begin mul_a = -e_q[5]; mul_c = C5; rnd = 1'b1; yidx = 3'd3; end
			OP_Y4:  begin mul_a = e_q[0] - e_q[1]; mul_c = C4; rnd = 1'b1; yidx = 3'd4; end
			OP_Y5A: begin mul_a = e_q[5]; mul_c = C3; end
			OP_Y5B: begin mul_a = e_q[6]; mul_c = C5; rnd = 1'b1; yidx = 3'd5; end
			OP_Y6A: begin mul_a = e_q[3]; mul_c = C6; end
			OP_Y6B: begin mul_a = -e_q[2]; mul_c = C2; rnd = 1'b1; yidx = 3'd6; end
			OP_Y7A: begin mul_a = e_q[7]; mul_c = C7; end
			OP_Y7B: begin mul_a = -e_q[4]; mul_c = C1; rnd = 1'b1; yidx = 3'd7; end
			default: ;
		endcase
	end

	assign prod = PROD_BITS'(mul_a) * $signed({1'b0, mul_c});

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			op_q <= OP_DONE;
		end else if (start) begin
			op_q <= OP_A;
		end else if (op_q != OP_DONE) begin
			op_q <= op_t'(op_q + 5'd1);
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			acc_q <= '0;
		end else begin
			unique case (op_q)
				OP_A: begin
					a_q[0] <= x[0] + x[7]; a_q[1] <= x[1] + x[6];
					a_q[2] <= x[2] + x[5]; a_q[3] <= x[3] + x[4];
					a_q[4] <= x[3] - x[4]; a_q[5] <= x[2] - x[5];
					a_q[6] <= x[1] - x[6]; a_q[7] <= x[0] - x[7];
				end
				OP_M5: m5_q <= round16(prod);
				OP_M7: m7_q <= round16(prod);
				OP_E: begin
					e_q[0] <= a_q[0] + a_q[3]; e_q[1] <= a_q[1] + a_q[2];
					e_q[2] <= a_q[1] - a_q[2]; e_q[3] <= a_q[0] - a_q[3];
					e_q[4] <= a_q[4] + m5_q;   e_q[5] <= a_q[4] - m5_q;
					e_q[6] <= a_q[7] - m7_q;   e_q[7] <= m7_q + a_q[7];
				end
				OP_DONE: ;
				default: begin
					if (rnd) begin
						y[yidx] <= round16(acc_q + prod);
						acc_q   <= '0;
					end else begin
						acc_q <= prod;
					end
				end
			endcase
		end
	end

	assign done = (op_q == OP_Y7B);

endmodule

>>> rtl/core/forward_dct_8x8_fixed_point.sv
// Top level: 8x8 forward DCT, sample gather, row and column passes, coefficient emit.
// channel | valid     | stall     | payload
// in      | in_valid  | in_stall  | sample
// out     | out_valid | out_stall | coefficient, last_of_block
// Gathers 64 samples, one a cycle. Then 16 line passes each take 8 reads, 18 engine
// steps on one shared multiplier and 8 writes; then 64 coefficients, each read from
// the block store before it is offered. Input is stalled during transform and emit.
// Reset clears the counters and state. Output stall holds the current coefficient.
module forward_dct_8x8_fixed_point
	import fdct_pkg::*;
(
	input  logic                         clk,
	input  logic                         arst_n,
	input  logic                         in_valid,
	output logic                         in_stall,
	input  logic [SAMPLE_BITS-1:0]       sample,
	output logic                         out_valid,
	input  logic                         out_stall,
	output logic [COEF_BITS-1:0]         coefficient,
	output logic                         last_of_block
);

	state_t state_q, state_d;
	logic signed [WORK_BITS-1:0] mem [64];
	logic [5:0]  cnt_q;
	logic [2:0]  k_q;
	logic [2:0]  rk;
	logic [3:0]  line_q;
	logic [5:0]  addr;
	logic signed [WORK_BITS-1:0] rd_q;
	logic        rd_ok_q;
	logic signed [7:0][WORK_BITS-1:0] x_q;
	logic signed [7:0][WORK_BITS-1:0] y;
	logic        start;
	logic        done;
	logic        in_go, out_go;
	logic signed [WORK_BITS-1:0] sat;

	fdct_line u_line (
		.clk(clk), .arst_n(arst_n), .start(start), .x(x_q), .y(y), .done(done)
	);

	assign in_go  = in_valid && !in_stall;
	assign out_go = out_valid && !out_stall;

	// read address runs one ahead of the capture index
	always_comb begin
		rk = k_q;
		if (state_q == ST_READ && rd_ok_q) rk = k_q + 3'd1;
		if (line_q[3]) addr = {rk, line_q[2:0]};
		else           addr = {line_q[2:0], rk};
	end

	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_LOAD:  if (in_go && cnt_q == 6'd63) state_d = ST_READ;
			ST_READ:  if (rd_ok_q && k_q == 3'd7) state_d = ST_CALC;
			ST_CALC:  if (done) state_d = ST_WRITE;
			ST_WRITE: if (k_q == 3'd7) state_d = (line_q == 4'd15) ? ST_EMIT : ST_READ;
			ST_EMIT:  if (out_go && cnt_q == 6'd63) state_d = ST_LOAD;
			default:  state_d = ST_LOAD;
		endcase
	end

	always_comb begin
		in_stall  = (state_q != ST_LOAD);
		out_valid = (state_q == ST_EMIT) && rd_ok_q;
		start     = (state_q == ST_READ) && rd_ok_q && (k_q == 3'd7);
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_LOAD;
			cnt_q   <= '0;
			k_q     <= '0;
			line_q  <= '0;
			rd_ok_q <= 1'b0;
		end else begin
			state_q <= state_d;
			unique case (state_q)
				ST_LOAD: begin
					if (in_go) cnt_q <= cnt_q + 6'd1;
					rd_ok_q <= 1'b0;
					k_q     <= '0;
					line_q  <= '0;
				end
				ST_READ: begin
					rd_ok_q <= 1'b1;
					if (rd_ok_q) begin
						k_q <= k_q + 3'd1;
						if (k_q == 3'd7) rd_ok_q <= 1'b0;
					end
				end
				ST_CALC: k_q <= '0;
				ST_WRITE: begin
					k_q <= k_q + 3'd1;
					if (k_q == 3'd7) line_q <= line_q + 4'd1;
					cnt_q <= '0;
				end
				ST_EMIT: begin
					if (!rd_ok_q) begin
						rd_ok_q <= 1'b1;
					end else if (out_go) begin
						cnt_q   <= cnt_q + 6'd1;
						rd_ok_q <= 1'b0;
					end
				end
				default: ;
			endcase
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_LOAD && in_go)
			mem[cnt_q] <= WORK_BITS'($signed(sample));
		else if (state_q == ST_WRITE)
			mem[addr] <= y[k_q];
		if (state_q == ST_EMIT)
			rd_q <= mem[cnt_q];
		else
			rd_q <= mem[addr];
		if (state_q == ST_READ && rd_ok_q)
			x_q[k_q] <= rd_q;
	end

	always_comb begin
		if (rd_q > WORK_BITS'(16383))       sat = WORK_BITS'(16383);
		else if (rd_q < -WORK_BITS'(16384)) sat = -WORK_BITS'(16384);
		else                                 sat = rd_q;
	end

	assign coefficient   = sat[COEF_BITS-1:0];
	assign last_of_block = (cnt_q == 6'd63);

`ifndef SYNTHESIS
	a_no_both: assert property (@(posedge clk) disable iff (!arst_n)
		!(out_valid && !in_stall)) else $error("input open while emitting");
	a_last_ends: assert property (@(posedge clk) disable iff (!arst_n)
		out_go && last_of_block |=> state_q == ST_LOAD) else $error("block end lost");
	a_start_read: assert property (@(posedge clk) disable iff (!arst_n)
		start |-> state_q == ST_READ) else $error("engine start out of phase");
`endif

endmodule

>>> tb/tb.sv
// Testbench for the 8x8 fixed-point forward DCT: fixed and random blocks checked by a predictor.
`timescale 1ns / 100ps

module tb;
	import fdct_pkg::*;

	localparam int WATCHDOG_LIMIT = 20000;

	logic clk;
	logic arst_n;
	logic in_valid;
	logic in_stall;
	logic [SAMPLE_BITS-1:0] sample;
	logic out_valid;
	logic out_stall;
	logic [COEF_BITS-1:0] coefficient;
	logic last_of_block;

	int error_count;
	int idle_pct_in;
	int idle_pct_out;
	int blocks_sent;
	int coefs_seen;
	int stall_cycles;
	bit input_done;

	typedef struct {
		logic [COEF_BITS-1:0] coefficient;
		logic last_of_block;
	} coef_t;

	task automatic report_mismatch(input string msg);
		$display("MISMATCH @%0t: %s", $realtime, msg);
		error_count++;
	endtask

	class dct_scoreboard;
		longint block_buf[64];
		int fill;
		coef_t pending[$];

		function longint rnd16(input longint v);
			return (v + 64'sd32768) >>> 16;
		endfunction

		function void lee_line(ref longint w[64], input int base, input int stride);
			longint s[8];
			longint a0, a1, a2, a3, a4, a5, a6, a7;
			longint e0, e1, e2, e3, e4, e5, e6, e7, m5, m7;
			for (int n = 0; n < 8; n++)
				s[n] = w[base + n * stride];
			a0 = s[0] + s[7]; a1 = s[1] + s[6]; a2 = s[2] + s[5]; a3 = s[3] + s[4];
			a4 = s[3] - s[4]; a5 = s[2] - s[5]; a6 = s[1] - s[6]; a7 = s[0] - s[7];
			e0 = a0 + a3; e1 = a1 + a2; e2 = a1 - a2; e3 = a0 - a3;
			m5 = rnd16((a6 - a5) * longint'(C4));
			m7 = rnd16((a5 + a6) * longint'(C4));
			e4 = a4 + m5; e5 = a4 - m5; e6 = a7 - m7; e7 = m7 + a7;
			w[base + 0 * stride] = rnd16((e0 + e1) * longint'(C4));
			w[base + 1 * stride] = rnd16(e4 * longint'(C7) + e7 * longint'(C1));
			w[base + 2 * stride] = rnd16(e2 * longint'(C6) + e3 * longint'(C2));
			w[base + 3 * stride] = rnd16(e6 * longint'(C3) - e5 * longint'(C5));
			w[base + 4 * stride] = rnd16((e0 - e1) * longint'(C4));
			w[base + 5 * stride] = rnd16(e5 * longint'(C3) + e6 * longint'(C5));
			w[base + 6 * stride] = rnd16(e3 * longint'(C6) - e2 * longint'(C2));
			w[base + 7 * stride] = rnd16(e7 * longint'(C7) - e4 * longint'(C1));
		endfunction

		function void note_sample(input logic [SAMPLE_BITS-1:0] s);
			longint w[64];
			longint c;
			coef_t r;
			block_buf[fill] = longint'($signed(s));
			fill = (fill + 1) % 64;
			if (fill != 0)
				return;
			w = block_buf;
			for (int k = 0; k < 8; k++)
				lee_line(w, k * 8, 1);
			for (int k = 0; k < 8; k++)
				lee_line(w, k, 8);
			for (int k = 0; k < 64; k++) begin
				c = w[k];
				if (c > 16383)
					c = 16383;
				if (c < -16384)
					c = -16384;
				r.coefficient = c[COEF_BITS-1:0];
				r.last_of_block = (k == 63);
				pending.push_back(r);
			end
		endfunction

		task check_coef(input logic [COEF_BITS-1:0] c, input logic l);
			coef_t e;
			if (pending.size() == 0) begin
				report_mismatch($sformatf("unexpected coefficient %0d", $signed(c)));
				return;
			end
			e = pending.pop_front();
			if (c !== e.coefficient)
				report_mismatch($sformatf("coefficient got %0d want %0d",
					$signed(c), $signed(e.coefficient)));
			if (l !== e.last_of_block)
				report_mismatch($sformatf("last_of_block got %0b want %0b",
					l, e.last_of_block));
		endtask
	endclass

	dct_scoreboard sb;

	forward_dct_8x8_fixed_point dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_stall(in_stall), .sample(sample),
		.out_valid(out_valid), .out_stall(out_stall),
		.coefficient(coefficient), .last_of_block(last_of_block)
	);

	initial begin
		clk = 0;
		forever #6 clk = ~clk;
	end

	// one transfer; valid stays high between back-to-back transfers
	task automatic send_sample(input logic [SAMPLE_BITS-1:0] s);
		while (idle_pct_in > 0 && $urandom_range(99) < idle_pct_in) begin
			in_valid <= 1'b0;
			@(posedge clk);
		end
		in_valid <= 1'b1;
		sample <= s;
		@(posedge clk);
		while (in_stall)
			@(posedge clk);
		sb.note_sample(s);
	endtask

	// pattern: 0 random, 1 all max, 2 all min, 3 checkerboard, 4 alternating bits
	task automatic send_block(input int pattern);
		logic [SAMPLE_BITS-1:0] s;
		for (int i = 0; i < 64; i++) begin
			case (pattern)
				1: s = 9'h0FF;
				2: s = 9'h100;
				3: s = (((i >> 3) ^ i) & 1) ? 9'h0FF : 9'h100;
				4: s = (i & 1) ? 9'h155 : 9'h0AA;
				default: s = $urandom;
			endcase
			send_sample(s);
		end
		blocks_sent++;
	endtask

	always @(posedge clk) begin
		if (arst_n) begin
			if (out_valid && !out_stall) begin
				sb.check_coef(coefficient, last_of_block);
				coefs_seen++;
			end
			if ((in_valid && !in_stall) || (out_valid && !out_stall))
				stall_cycles = 0;
			else
				stall_cycles++;
			if (stall_cycles >= WATCHDOG_LIMIT) begin
				$display("Watchdog expired with %0d coefficients pending", sb.pending.size());
				$display("Verification failed");
				$finish;
			end
			out_stall <= (idle_pct_out > 0 && $urandom_range(99) < idle_pct_out);
		end
	end

	initial begin
		sb = new();
		error_count = 0;
		blocks_sent = 0;
		coefs_seen = 0;
		stall_cycles = 0;
		idle_pct_in = 14;
		idle_pct_out = 14;
		arst_n = 0;
		in_valid = 0;
		sample = '0;
		out_stall = 0;
		repeat (12) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);
		send_block(1);
		send_block(3);
		idle_pct_in = 0;
		idle_pct_out = 0;
		send_block(0);
		idle_pct_in = 14;
		idle_pct_out = 14;
		send_block(0);
		in_valid <= 1'b0;
		while (sb.pending.size() != 0)
			@(posedge clk);
		repeat (50) @(posedge clk);
		$display("Ran %0d blocks (full-scale, checkerboard, random), %0d coefficients",
			blocks_sent, coefs_seen);
		if (error_count == 0)
			$display("Verification passed");
		else
			$display("Verification failed");
		$finish;
	end
endmodule
